// File: rtl/atclp_pkg.sv
// Shared types and constants for the AT command line parser.
package atclp_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 10;
    localparam int EVT_W  = 2;
    localparam int KIND_W = 2;

    typedef enum logic [1:0] {
        PH_HUNT_A = 2'd0,
        PH_HUNT_T = 2'd1,
        PH_LINE   = 2'd2
    } t_phase;

    localparam logic [KIND_W-1:0] KIND_ACT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PARA = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TEST = 2'd3;

    localparam logic [EVT_W-1:0] EVT_COMPLETE  = 2'd0;
    localparam logic [EVT_W-1:0] EVT_MALFORMED = 2'd1;
    localparam logic [EVT_W-1:0] EVT_TOO_LONG  = 2'd2;

    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_UPPER_T = 8'h54;
    localparam logic [BYTE_W-1:0] CH_LOWER_T = 8'h74;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_BS      = 8'h08;
    localparam logic [BYTE_W-1:0] CH_EQUAL   = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_QUERY   = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

    typedef struct packed {
        t_phase             phase;
        logic [LEN_W-1:0]   line_count;
        logic [LEN_W-1:0]   op_pos;
        logic [KIND_W-1:0]  kind;
        logic               op_was_equal;
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [EVT_W-1:0]   event_res;
        logic [KIND_W-1:0]  cmd_type;
        logic [LEN_W-1:0]   name_length;
        logic [LEN_W-1:0]   line_length;
    } t_result;

endpackage

// File: rtl/atclp_if.sv
// Handshake interfaces for received bytes and parser results.
interface atclp_byte_if;
    logic                          valid;
    logic                          ready;
    logic [atclp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface atclp_res_if;
    logic                          valid;
    logic                          ready;
    logic [atclp_pkg::EVT_W-1:0]   event_res;
    logic [atclp_pkg::KIND_W-1:0]  cmd_type;
    logic [atclp_pkg::LEN_W-1:0]   name_length;
    logic [atclp_pkg::LEN_W-1:0]   line_length;

    modport source (output valid, output event_res, output cmd_type,
                    output name_length, output line_length, input ready);
    modport sink   (input valid, input event_res, input cmd_type,
                    input name_length, input line_length, output ready);
endinterface

// File: rtl/atclp_step.sv
// Next-state and result logic for one received byte.
module atclp_step #(
    parameter int MAX_LINE = 512
) (
    input  atclp_pkg::t_state                 i_state,
    input  logic [atclp_pkg::BYTE_W-1:0]      i_byte,
    output atclp_pkg::t_state                 o_state,
    output atclp_pkg::t_result                o_result
);

    localparam logic [atclp_pkg::LEN_W-1:0] MAX_LEN = atclp_pkg::LEN_W'(MAX_LINE);

    logic                            w_is_param;
    logic [atclp_pkg::LEN_W-1:0]     w_count_inc;
    logic [atclp_pkg::LEN_W-1:0]     w_count_dec;
    logic [atclp_pkg::LEN_W:0]       w_op_plus1;
    logic [atclp_pkg::LEN_W:0]       w_op_plus2;
    logic                            w_malformed;
    logic                            w_done;

    assign w_is_param  = (i_byte == atclp_pkg::CH_EQUAL) ||
                         (i_byte >= atclp_pkg::CH_ZERO && i_byte <= atclp_pkg::CH_NINE);
    assign w_count_inc = i_state.line_count + 1'b1;
    assign w_count_dec = i_state.line_count - 1'b1;
    assign w_op_plus1  = {1'b0, i_state.op_pos} + 1'b1;
    assign w_op_plus2  = {1'b0, i_state.op_pos} + 2'd2;
    assign w_malformed =
        (i_state.kind == atclp_pkg::KIND_READ &&
         w_op_plus1 != {1'b0, i_state.line_count}) ||
        (i_state.kind == atclp_pkg::KIND_TEST &&
         w_op_plus2 != {1'b0, i_state.line_count});

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        w_done   = 1'b0;
        case (i_state.phase)
            atclp_pkg::PH_HUNT_A: begin
                if (i_byte == atclp_pkg::CH_UPPER_A || i_byte == atclp_pkg::CH_LOWER_A) begin
                    o_state.phase      = atclp_pkg::PH_HUNT_T;
                    o_state.line_count = w_count_inc;
                end
            end
            atclp_pkg::PH_HUNT_T: begin
                if (i_byte == atclp_pkg::CH_UPPER_T || i_byte == atclp_pkg::CH_LOWER_T) begin
                    o_state.phase      = atclp_pkg::PH_LINE;
                    o_state.line_count = w_count_inc;
                end else begin
                    o_state.phase      = atclp_pkg::PH_HUNT_A;
                    o_state.line_count = '0;
                    o_state.op_pos     = '0;
                end
            end
            atclp_pkg::PH_LINE: begin
                if (i_byte == atclp_pkg::CH_CR) begin
                    w_done         = 1'b1;
                    o_result.valid = 1'b1;
                    if (i_state.op_pos == '0) begin
                        // No operator: the whole line is the command name.
                        o_state.kind         = atclp_pkg::KIND_ACT;
                        o_result.event_res   = atclp_pkg::EVT_COMPLETE;
                        o_result.cmd_type    = atclp_pkg::KIND_ACT;
                        o_result.name_length = i_state.line_count;
                        o_result.line_length = i_state.line_count;
                    end else if (w_malformed) begin
                        o_result.event_res   = atclp_pkg::EVT_MALFORMED;
                    end else begin
                        o_result.event_res   = atclp_pkg::EVT_COMPLETE;
                        o_result.cmd_type    = i_state.kind;
                        o_result.name_length = i_state.op_pos;
                        o_result.line_length = i_state.line_count;
                    end
                    o_state.phase      = atclp_pkg::PH_HUNT_A;
                    o_state.line_count = '0;
                    o_state.op_pos     = '0;
                end else if (i_byte == atclp_pkg::CH_BS) begin
                    if (i_state.line_count != '0) begin
                        o_state.line_count = w_count_dec;
                        if (w_count_dec == i_state.op_pos) begin
                            o_state.op_pos = '0;
                        end
                    end
                end else begin
                    o_state.line_count = w_count_inc;
                    if (w_is_param) begin
                        if (i_state.op_pos == '0) begin
                            o_state.op_pos       = i_state.line_count;
                            o_state.kind         = atclp_pkg::KIND_PARA;
                            o_state.op_was_equal = (i_byte == atclp_pkg::CH_EQUAL);
                        end
                    end else if (i_byte == atclp_pkg::CH_QUERY) begin
                        if (i_state.op_pos == '0) begin
                            o_state.op_pos       = i_state.line_count;
                            o_state.kind         = atclp_pkg::KIND_READ;
                            o_state.op_was_equal = 1'b0;
                        end else if (i_state.op_was_equal &&
                                     {1'b0, i_state.line_count} == w_op_plus1) begin
                            o_state.kind = atclp_pkg::KIND_TEST;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        if (!w_done && o_state.line_count >= MAX_LEN) begin
            o_state.phase      = atclp_pkg::PH_HUNT_A;
            o_state.line_count = '0;
            o_state.op_pos     = '0;
            o_result           = '0;
            o_result.valid     = 1'b1;
            o_result.event_res = atclp_pkg::EVT_TOO_LONG;
        end
    end

endmodule

// File: rtl/at_command_line_parser_core.sv
// A result word passes from the input register through the step logic into the result register.
// Throughput: one byte per cycle while the result register is free; the parser state updates in a single pass per byte.
// A stalled result holds in the result register; the input register then takes one more byte if empty.
// Reset (synchronous, active low) empties both registers and returns to hunting for 'A'
// with an empty line, no operator and an action command kind.
module at_command_line_parser_core #(
    parameter int MAX_LINE = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    atclp_byte_if.sink         i_rx,
    atclp_res_if.source        o_res
);

    logic                               r_in_valid;
    logic [atclp_pkg::BYTE_W-1:0]       r_byte;
    atclp_pkg::t_state                  r_state;
    atclp_pkg::t_state                  n_state;
    atclp_pkg::t_result                 w_step_res;
    logic                               r_out_valid;
    logic [atclp_pkg::EVT_W-1:0]        r_event_res;
    logic [atclp_pkg::KIND_W-1:0]       r_cmd_type;
    logic [atclp_pkg::LEN_W-1:0]        r_name_length;
    logic [atclp_pkg::LEN_W-1:0]        r_line_length;
    logic                               w_out_free;
    logic                               w_advance;
    logic                               w_in_ready;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign w_in_ready = !r_in_valid || w_out_free;

    assign i_rx.ready        = w_in_ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.event_res   = r_event_res;
    assign o_res.cmd_type    = r_cmd_type;
    assign o_res.name_length = r_name_length;
    assign o_res.line_length = r_line_length;

    atclp_step #(
        .MAX_LINE (MAX_LINE)
    ) u_step (
        .i_state  (r_state),
        .i_byte   (r_byte),
        .o_state  (n_state),
        .o_result (w_step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_rx.valid) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= atclp_pkg::PH_HUNT_A;
            r_state.line_count   <= '0;
            r_state.op_pos       <= '0;
            r_state.kind         <= atclp_pkg::KIND_ACT;
            r_state.op_was_equal <= 1'b0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_step_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_step_res.valid) begin
            r_event_res   <= w_step_res.event_res;
            r_cmd_type    <= w_step_res.cmd_type;
            r_name_length <= w_step_res.name_length;
            r_line_length <= w_step_res.line_length;
        end
    end

    // Error words carry no command details.
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event_res != atclp_pkg::EVT_COMPLETE) |->
        (r_cmd_type == '0 && r_name_length == '0 && r_line_length == '0))
        else $error("error word carries nonzero command fields");

    a_count_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.line_count < atclp_pkg::LEN_W'(MAX_LINE))
        else $error("line count reached the length limit without being cleared");

    // A held operator always lies inside the current line.
    a_op_inside_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.op_pos != '0) |-> (r_state.op_pos < r_state.line_count))
        else $error("operator position outside the line");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_advance && $past(i_rst_n)) |=> (r_state == $past(r_state)))
        else $error("parser state changed without a byte being processed");

endmodule
